[hdl/kps_pkg.sv]
// kps_pkg: shared types and constants of the k-nearest point selector
// depends on nothing; used by the channel interfaces and all modules

package kps_pkg;

    // payload widths
    localparam int ID_W       = 10;
    localparam int POS_W      = 16;
    localparam int SEL_W      = 4;
    localparam int DIFF_W     = POS_W + 1;
    localparam int MAG_W      = POS_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_COUNT = CFG_IDX_W'(3);

    // reset value of the select count
    localparam logic [SEL_W-1:0] SELECT_COUNT_RESET = SEL_W'(8);

    // axis handled by the shared squaring unit
    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } kps_axis_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_DECIDE,
        ST_SCAN,
        ST_REPLACE,
        ST_EMIT
    } kps_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      sq_en;
        kps_axis_t sq_axis;
        logic      acc_en;
        logic      write_new;
        logic      scan_start;
        logic      scan_step;
        logic      replace;
        logic      emit_start;
        logic      emit_step;
        logic      clear;
    } kps_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic new_active;
        logic new_last;
        logic item_last;
        logic held_lt_limit;
        logic held_zero;
        logic scan_done;
        logic emit_last;
    } kps_status_t;

endpackage

[hdl/kps_channels.sv]
// kps_channels: valid/ready channel interfaces for points, results and config writes
// depends on kps_pkg for payload widths

interface kps_point_if;
    logic                            valid;
    logic                            ready;
    logic [kps_pkg::ID_W-1:0]        point_id;
    logic signed [kps_pkg::POS_W-1:0] pos_x;
    logic signed [kps_pkg::POS_W-1:0] pos_y;
    logic signed [kps_pkg::POS_W-1:0] pos_z;
    logic                            active;
    logic                            last_point;

    modport source (output valid, point_id, pos_x, pos_y, pos_z, active, last_point,
                    input ready);
    modport sink   (input valid, point_id, pos_x, pos_y, pos_z, active, last_point,
                    output ready);
endinterface

interface kps_result_if;
    logic                     valid;
    logic                     ready;
    logic [kps_pkg::ID_W-1:0] chosen_id;
    logic                     found;
    logic                     last_result;

    modport source (output valid, chosen_id, found, last_result, input ready);
    modport sink   (input valid, chosen_id, found, last_result, output ready);
endinterface

interface kps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kps_pkg::CFG_IDX_W-1:0]  index;
    logic [kps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/kps_datapath.sv]
// kps_datapath: config registers, distance unit, slot store, furthest search and emit index
// depends on kps_pkg; driven by kps_controller through command and status structs

module kps_datapath #(
    parameter int MAX_SELECT = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kps_pkg::kps_cmd_t                 cmd,
    output kps_pkg::kps_status_t              status,
    // candidate fields
    input  logic [kps_pkg::ID_W-1:0]          point_id,
    input  logic signed [kps_pkg::POS_W-1:0]  pos_x,
    input  logic signed [kps_pkg::POS_W-1:0]  pos_y,
    input  logic signed [kps_pkg::POS_W-1:0]  pos_z,
    input  logic                              active,
    input  logic                              last_point,
    // configuration writes
    input  logic                              cfg_write,
    input  logic [kps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kps_pkg::CFG_DATA_W-1:0]    cfg_data,
    // result fields
    output logic [kps_pkg::ID_W-1:0]          chosen_id,
    output logic                              found,
    output logic                              last_result
);

    localparam int IDX_W = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
    localparam int CNT_W = $clog2(MAX_SELECT + 1);

    // configuration
    logic signed [kps_pkg::POS_W-1:0] query_x_reg, query_y_reg, query_z_reg;
    logic [kps_pkg::SEL_W-1:0]        select_count_reg;

    // latched item
    logic [kps_pkg::ID_W-1:0]         id_reg;
    logic                             last_reg;
    logic signed [kps_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [kps_pkg::SQ_W-1:0]         sq_reg;
    logic [kps_pkg::DIST_W-1:0]       acc_reg;

    // slot store
    logic [kps_pkg::ID_W-1:0]         slot_id_reg   [MAX_SELECT];
    logic [kps_pkg::DIST_W-1:0]       slot_dist_reg [MAX_SELECT];
    logic [CNT_W-1:0]                 held_reg;

    // search and emit
    logic [CNT_W-1:0]                 idx_reg;
    logic [IDX_W-1:0]                 far_idx_reg;
    logic [kps_pkg::DIST_W-1:0]       far_dist_reg;

    logic signed [kps_pkg::DIFF_W-1:0] sel_diff;
    logic [kps_pkg::DIFF_W-1:0]        sel_abs;
    logic [kps_pkg::MAG_W-1:0]         sel_mag;
    logic [IDX_W-1:0]                  rd_idx;
    logic [IDX_W-1:0]                  wr_idx;
    logic [kps_pkg::DIST_W-1:0]        rd_dist;
    logic [kps_pkg::ID_W-1:0]          rd_id;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg      <= '0;
            query_y_reg      <= '0;
            query_z_reg      <= '0;
            select_count_reg <= kps_pkg::SELECT_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                kps_pkg::REG_QUERY_X:      query_x_reg      <= cfg_data;
                kps_pkg::REG_QUERY_Y:      query_y_reg      <= cfg_data;
                kps_pkg::REG_QUERY_Z:      query_z_reg      <= cfg_data;
                kps_pkg::REG_SELECT_COUNT: select_count_reg <= cfg_data[kps_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // axis select and magnitude for the shared squaring unit
    always_comb
    begin
        case (cmd.sq_axis)
            kps_pkg::AXIS_X: sel_diff = dx_reg;
            kps_pkg::AXIS_Y: sel_diff = dy_reg;
            kps_pkg::AXIS_Z: sel_diff = dz_reg;
            default:         sel_diff = dx_reg;
        endcase
        sel_abs = sel_diff[kps_pkg::DIFF_W-1] ? (-sel_diff) : sel_diff;
        sel_mag = sel_abs[kps_pkg::MAG_W-1:0];
    end

    // slot read port, one address at a time
    assign rd_idx  = idx_reg[IDX_W-1:0];
    assign wr_idx  = held_reg[IDX_W-1:0];
    assign rd_dist = slot_dist_reg[rd_idx];
    assign rd_id   = slot_id_reg[rd_idx];

    // item latch, distance accumulation, slot writes, search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg   <= point_id;
            last_reg <= last_point;
            dx_reg   <= {pos_x[kps_pkg::POS_W-1], pos_x} - {query_x_reg[kps_pkg::POS_W-1], query_x_reg};
            dy_reg   <= {pos_y[kps_pkg::POS_W-1], pos_y} - {query_y_reg[kps_pkg::POS_W-1], query_y_reg};
            dz_reg   <= {pos_z[kps_pkg::POS_W-1], pos_z} - {query_z_reg[kps_pkg::POS_W-1], query_z_reg};
            sq_reg   <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (cmd.sq_en)
                sq_reg <= sel_mag * sel_mag;
            if (cmd.acc_en)
                acc_reg <= acc_reg + {2'b00, sq_reg};
        end

        if (cmd.write_new)
        begin
            slot_id_reg[wr_idx]   <= id_reg;
            slot_dist_reg[wr_idx] <= acc_reg;
        end
        else if (cmd.replace && (acc_reg < far_dist_reg))
        begin
            slot_id_reg[far_idx_reg]   <= id_reg;
            slot_dist_reg[far_idx_reg] <= acc_reg;
        end

        if (cmd.scan_start)
        begin
            far_idx_reg  <= '0;
            far_dist_reg <= slot_dist_reg[0];
        end
        else if (cmd.scan_step && (rd_dist > far_dist_reg))
        begin
            far_idx_reg  <= rd_idx;
            far_dist_reg <= rd_dist;
        end
    end

    // fill count and shared scan/emit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
                held_reg <= '0;
            else if (cmd.write_new)
                held_reg <= held_reg + CNT_W'(1);

            if (cmd.scan_start)
                idx_reg <= CNT_W'(1);
            else if (cmd.emit_start)
                idx_reg <= '0;
            else if (cmd.scan_step || cmd.emit_step)
                idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // status to the controller
    always_comb
    begin
        status.new_active    = active;
        status.new_last      = last_point;
        status.item_last     = last_reg;
        status.held_lt_limit = (32'(held_reg) < 32'(select_count_reg))
                               && (32'(held_reg) < MAX_SELECT);
        status.held_zero     = (held_reg == '0);
        status.scan_done     = (idx_reg == held_reg);
        status.emit_last     = (held_reg == '0) || ((idx_reg + CNT_W'(1)) == held_reg);
    end

    // result payload
    assign chosen_id   = status.held_zero ? '0 : rd_id;
    assign found       = !status.held_zero;
    assign last_result = status.emit_last;

endmodule

[hdl/kps_controller.sv]
// kps_controller: state machine sequencing distance, insert/replace search and emission
// depends on kps_pkg; commands kps_datapath and owns the channel handshakes

module kps_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  kps_pkg::kps_status_t status,
    output kps_pkg::kps_cmd_t    cmd
);

    kps_pkg::kps_state_t state_reg, state_next;
    kps_pkg::kps_axis_t  axis_reg, axis_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kps_pkg::ST_IDLE;
            axis_reg  <= kps_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.sq_axis = axis_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        case (state_reg)
            kps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.new_active)
                    begin
                        axis_next  = kps_pkg::AXIS_X;
                        state_next = kps_pkg::ST_SQUARE;
                    end
                    else if (status.new_last)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = kps_pkg::ST_EMIT;
                    end
                end
            end

            // one axis squared per cycle, previous square added
            kps_pkg::ST_SQUARE:
            begin
                cmd.sq_en  = 1'b1;
                cmd.acc_en = 1'b1;
                case (axis_reg)
                    kps_pkg::AXIS_X: axis_next = kps_pkg::AXIS_Y;
                    kps_pkg::AXIS_Y: axis_next = kps_pkg::AXIS_Z;
                    default:
                    begin
                        axis_next  = kps_pkg::AXIS_X;
                        state_next = kps_pkg::ST_SUM;
                    end
                endcase
            end

            kps_pkg::ST_SUM:
            begin
                cmd.acc_en = 1'b1;
                state_next = kps_pkg::ST_DECIDE;
            end

            // insert while filling, else search the furthest entry, or drop the item when no slot is held
            kps_pkg::ST_DECIDE:
            begin
                if (status.held_lt_limit)
                begin
                    cmd.write_new = 1'b1;
                    if (status.item_last)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = kps_pkg::ST_EMIT;
                    end
                    else
                        state_next = kps_pkg::ST_IDLE;
                end
                else if (!status.held_zero)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = kps_pkg::ST_SCAN;
                end
                else if (status.item_last)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = kps_pkg::ST_EMIT;
                end
                else
                    state_next = kps_pkg::ST_IDLE;
            end

            kps_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = kps_pkg::ST_REPLACE;
                else
                    cmd.scan_step = 1'b1;
            end

            kps_pkg::ST_REPLACE:
            begin
                cmd.replace = 1'b1;
                if (status.item_last)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = kps_pkg::ST_EMIT;
                end
                else
                    state_next = kps_pkg::ST_IDLE;
            end

            // one result per transfer, store cleared after the final one
            kps_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = kps_pkg::ST_IDLE;
                    end
                    else
                        cmd.emit_step = 1'b1;
                end
            end

            default:
                state_next = kps_pkg::ST_IDLE;
        endcase
    end

endmodule

[hdl/k_nearest_point_selector_top.sv]
// k_nearest_point_selector_top: one candidate at a time; an inactive non-final one is dropped, an
// active one inserted while filling, once full swapped for the furthest slot (furthest-slot scan) if nearer
// the final candidate adds one result per cycle while result.ready is high, held count or one
// rst_n (async, active low) empties the store and loads query 0 and select count 8
// depends on kps_pkg, kps_channels, kps_controller and kps_datapath

module k_nearest_point_selector_top #(
    parameter int MAX_SELECT = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    kps_point_if.sink     point,
    kps_result_if.source  result,
    kps_cfg_if.sink       cfg
);

    kps_pkg::kps_cmd_t    cmd;
    kps_pkg::kps_status_t status;

    // config writes are always taken
    assign cfg.ready = 1'b1;

    kps_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    kps_datapath #(
        .MAX_SELECT (MAX_SELECT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .point_id    (point.point_id),
        .pos_x       (point.pos_x),
        .pos_y       (point.pos_y),
        .pos_z       (point.pos_z),
        .active      (point.active),
        .last_point  (point.last_point),
        .cfg_write   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .chosen_id   (result.chosen_id),
        .found       (result.found),
        .last_result (result.last_result)
    );

endmodule

[hdl/kps_checker.sv]
// kps_checker: port-level assertions for the k-nearest point selector
// depends on kps_pkg; bound to k_nearest_point_selector_top

module kps_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     point_valid,
    input logic                     point_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic [kps_pkg::ID_W-1:0] chosen_id,
    input logic                     found,
    input logic                     last_result
);

    // no candidate taken while results are pending
    a_no_accept_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !point_ready)
        else $error("candidate ready while a result is pending");

    // an empty selection is a single final result
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> last_result)
        else $error("none-found result not marked final");

    // an empty selection reports id zero
    a_empty_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (chosen_id == '0))
        else $error("none-found result with nonzero id");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(chosen_id)
            && $stable(found) && $stable(last_result)))
        else $error("stalled result changed");

endmodule

bind k_nearest_point_selector_top kps_checker u_kps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point.valid),
    .point_ready  (point.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .chosen_id    (result.chosen_id),
    .found        (result.found),
    .last_result  (result.last_result)
);
